// ===== src/kpec_pkg.sv =====
`timescale 1ns / 1ps
package kpec_pkg;

   localparam int NUM_KEYS = 18;
   localparam int TIME_BITS = 16;
   localparam int MASK_BITS = 18;
   localparam int CFG_TIME_BITS = 16;
   localparam int CMP_BITS = (TIME_BITS > CFG_TIME_BITS) ? TIME_BITS : CFG_TIME_BITS;
   localparam int KEY_CNT_BITS = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int KEY_IDX_BITS = 5;
   localparam int EVENT_BITS = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 18;
   localparam int TICK_BITS = 32;
   localparam int KEY_BITS = 16;

   localparam logic [EVENT_BITS-1:0] EV_NONE     = 3'd0;
   localparam logic [EVENT_BITS-1:0] EV_DOWN     = 3'd1;
   localparam logic [EVENT_BITS-1:0] EV_UP       = 3'd2;
   localparam logic [EVENT_BITS-1:0] EV_CLICK    = 3'd3;
   localparam logic [EVENT_BITS-1:0] EV_PRESSING = 3'd4;
   localparam logic [EVENT_BITS-1:0] EV_LONG     = 3'd5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLICK_DELAY = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MASK_NONE   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MASK_CTRL   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MASK_SHIFT  = 3'd4;

   localparam logic [CFG_TIME_BITS-1:0] CLICK_DELAY_RESET = 16'd50;
   localparam logic [CFG_TIME_BITS-1:0] LONG_PRESS_RESET  = 16'd1000;

   typedef struct packed {
      logic capture;
      logic step;
   } ctl_cmd_type;

   typedef struct packed {
      logic last_key;
   } ctl_sts_type;

endpackage

// ===== src/kpec_ctrl.sv =====
`timescale 1ns / 1ps
module kpec_ctrl
   import kpec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ctl_cmd_type cmd,
   input  ctl_sts_type sts
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.step    = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
      state_in    = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cmd.step && sts.last_key) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_RUN))
      else $error("accepted item did not start a run");
   a_step_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (state_ff == ST_RUN))
      else $error("key step outside a run");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && sts.last_key) |=> (state_ff == ST_IDLE) && rsp_valid)
      else $error("run did not end after last key");
`endif

endmodule

// ===== src/kpec_datapath.sv =====
`timescale 1ns / 1ps
module kpec_datapath
   import kpec_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_cmd_type               cmd,
   output ctl_sts_type               sts,
   input  logic [KEY_BITS-1:0]       req_key_bits,
   input  logic                      req_mouse_left,
   input  logic                      req_mouse_right,
   input  logic                      req_ctrl_held,
   input  logic                      req_shift_held,
   input  logic [TICK_BITS-1:0]      req_tick_now,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output logic [KEY_IDX_BITS-1:0]   rsp_key_index,
   output logic [EVENT_BITS-1:0]     rsp_event_code,
   output logic                      rsp_is_active,
   output logic                      rsp_notify,
   output logic                      rsp_last_of_run
);

   logic [CFG_TIME_BITS-1:0] click_delay_ff;
   logic [CFG_TIME_BITS-1:0] long_press_ff;
   logic [MASK_BITS-1:0]     mask_none_ff;
   logic [MASK_BITS-1:0]     mask_ctrl_ff;
   logic [MASK_BITS-1:0]     mask_shift_ff;

   logic [NUM_KEYS-1:0]      level_ff;
   logic [NUM_KEYS-1:0]      level_in;
   logic                     ctrl_ff;
   logic                     shift_ff;
   logic [TIME_BITS-1:0]     now_ff;
   logic [TIME_BITS-1:0]     prev_tick_ff;
   logic [KEY_CNT_BITS-1:0]  key_cnt_ff;

   logic [NUM_KEYS-1:0]      prev_level_ff;
   logic [TIME_BITS-1:0]     press_start_ff [NUM_KEYS];
   logic [EVENT_BITS-1:0]    held_event_ff [NUM_KEYS];

   logic [NUM_KEYS-1:0]      active_vec;
   logic [NUM_KEYS-1:0]      notify_vec;
   logic [MASK_BITS-1:0]     cur_mask;

   logic [KEY_IDX_BITS-1:0]  key_index_ff;
   logic [EVENT_BITS-1:0]    event_code_ff;
   logic                     is_active_ff;
   logic                     notify_ff;
   logic                     last_of_run_ff;

   logic                     lvl;
   logic                     was;
   logic                     active;
   logic [TIME_BITS-1:0]     start;
   logic [CMP_BITS-1:0]      press;
   logic [CMP_BITS-1:0]      last;
   logic [CMP_BITS-1:0]      click_cmp;
   logic [CMP_BITS-1:0]      long_cmp;
   logic [EVENT_BITS-1:0]    event_in;

   assign cur_mask = ctrl_ff ? mask_ctrl_ff : (shift_ff ? mask_shift_ff : mask_none_ff);

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      if (k < KEY_BITS) begin : g_kb
         assign level_in[k] = req_key_bits[k];
      end else if (k == KEY_BITS) begin : g_ml
         assign level_in[k] = req_mouse_left;
      end else if (k == KEY_BITS + 1) begin : g_mr
         assign level_in[k] = req_mouse_right;
      end else begin : g_none
         assign level_in[k] = 1'b0;
      end
      if (k < MASK_BITS) begin : g_mask
         assign active_vec[k] = mask_none_ff[k] | mask_ctrl_ff[k] | mask_shift_ff[k];
         assign notify_vec[k] = cur_mask[k];
      end else begin : g_nomask
         assign active_vec[k] = 1'b0;
         assign notify_vec[k] = 1'b0;
      end
   end

   always_comb begin
      lvl       = level_ff[key_cnt_ff];
      was       = prev_level_ff[key_cnt_ff];
      active    = active_vec[key_cnt_ff];
      start     = press_start_ff[key_cnt_ff];
      press     = CMP_BITS'(TIME_BITS'(now_ff - start));
      last      = CMP_BITS'(TIME_BITS'(prev_tick_ff - start));
      click_cmp = CMP_BITS'(click_delay_ff);
      long_cmp  = CMP_BITS'(long_press_ff);
      event_in  = held_event_ff[key_cnt_ff];
      case ({was, lvl})
         2'b01: event_in = EV_DOWN;
         2'b10: begin
            event_in = (press > click_cmp && press < long_cmp) ? EV_CLICK : EV_UP;
         end
         2'b11: begin
            if (press > click_cmp) begin
               event_in = EV_PRESSING;
            end
            if (last <= long_cmp && press > long_cmp) begin
               event_in = EV_LONG;
            end
         end
         default: event_in = EV_NONE;
      endcase
   end

   assign sts.last_key = (key_cnt_ff == KEY_CNT_BITS'(NUM_KEYS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         click_delay_ff <= CLICK_DELAY_RESET;
         long_press_ff  <= LONG_PRESS_RESET;
         mask_none_ff   <= '0;
         mask_ctrl_ff   <= '0;
         mask_shift_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CLICK_DELAY: click_delay_ff <= csr_data[CFG_TIME_BITS-1:0];
            CSR_LONG_PRESS:  long_press_ff  <= csr_data[CFG_TIME_BITS-1:0];
            CSR_MASK_NONE:   mask_none_ff   <= csr_data[MASK_BITS-1:0];
            CSR_MASK_CTRL:   mask_ctrl_ff   <= csr_data[MASK_BITS-1:0];
            CSR_MASK_SHIFT:  mask_shift_ff  <= csr_data[MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         prev_tick_ff  <= '0;
         key_cnt_ff    <= '0;
         prev_level_ff <= '0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            press_start_ff[i] <= '0;
            held_event_ff[i]  <= EV_NONE;
         end
      end else if (cmd.capture) begin
         level_ff     <= level_in;
         ctrl_ff      <= req_ctrl_held;
         shift_ff     <= req_shift_held;
         prev_tick_ff <= now_ff;
         now_ff       <= req_tick_now[TIME_BITS-1:0];
         key_cnt_ff   <= '0;
      end else if (cmd.step) begin
         key_cnt_ff <= key_cnt_ff + KEY_CNT_BITS'(1);
         if (active) begin
            prev_level_ff[key_cnt_ff] <= lvl;
            held_event_ff[key_cnt_ff] <= event_in;
            if (!was && lvl) begin
               press_start_ff[key_cnt_ff] <= now_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         key_index_ff   <= KEY_IDX_BITS'(key_cnt_ff);
         event_code_ff  <= active ? event_in : EV_NONE;
         is_active_ff   <= active;
         notify_ff      <= active & notify_vec[key_cnt_ff];
         last_of_run_ff <= sts.last_key;
      end
   end

   assign rsp_key_index   = key_index_ff;
   assign rsp_event_code  = event_code_ff;
   assign rsp_is_active   = is_active_ff;
   assign rsp_notify      = notify_ff;
   assign rsp_last_of_run = last_of_run_ff;

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (key_cnt_ff <= KEY_CNT_BITS'(NUM_KEYS - 1)))
      else $error("key counter out of range");
   a_notify_active: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.step) |-> (!rsp_notify || rsp_is_active))
      else $error("notify on inactive key");
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.step))
      else $error("capture and step together");
`endif

endmodule

// ===== src/key_press_event_classifier.sv =====
`timescale 1ns / 1ps
// The item is captured on transfer and the first result is registered on
// the first key step. One result per cycle follows while the output is
// not stalled, one per key, NUM_KEYS results in key order. A new item is
// taken only when idle; one shared key-evaluation step serves all keys.
// Reset: synchronous, active high; restores threshold and mask defaults and
// clears per-key history (prior level, start, event) and the previous tick.
module key_press_event_classifier
   import kpec_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [KEY_BITS-1:0]       req_key_bits,
   input  logic                      req_mouse_left,
   input  logic                      req_mouse_right,
   input  logic                      req_ctrl_held,
   input  logic                      req_shift_held,
   input  logic [TICK_BITS-1:0]      req_tick_now,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [KEY_IDX_BITS-1:0]   rsp_key_index,
   output logic [EVENT_BITS-1:0]     rsp_event_code,
   output logic                      rsp_is_active,
   output logic                      rsp_notify,
   output logic                      rsp_last_of_run,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign csr_ready = 1'b1;

   kpec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   kpec_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_key_bits    (req_key_bits),
      .req_mouse_left  (req_mouse_left),
      .req_mouse_right (req_mouse_right),
      .req_ctrl_held   (req_ctrl_held),
      .req_shift_held  (req_shift_held),
      .req_tick_now    (req_tick_now),
      .csr_write       (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_key_index   (rsp_key_index),
      .rsp_event_code  (rsp_event_code),
      .rsp_is_active   (rsp_is_active),
      .rsp_notify      (rsp_notify),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
